>>> hdl/paged_translate_fifo_replace_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the paged translation block
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGED_TRANSLATE_FIFO_REPLACE_ASSERT_SVH
`define PAGED_TRANSLATE_FIFO_REPLACE_ASSERT_SVH

// Implication within the same cycle.
`define PTFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define PTFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ptfr_pkg.sv
// ----------------------------------------------------------------------------
// ptfr_pkg
// Types and codes shared by the paged translation block with FIFO replacement.
// ----------------------------------------------------------------------------
package ptfr_pkg;

    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int PAGE_W   = 6;
    localparam int FRAME_W  = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;

    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSTALL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FAULT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INSTALLED = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  logical_address;
        logic [PAGE_W-1:0]  install_page;
        logic [FRAME_W-1:0] install_frame;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   physical_address;
        logic [PAGE_W-1:0]   evicted_page;
        logic                needs_writeback;
    } t_rsp;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               resident;
        logic               dirty;
    } t_pte;

    typedef struct packed {
        logic append;
        logic advance;
    } t_ring_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

endpackage

>>> hdl/ptfr_ram.sv
// ----------------------------------------------------------------------------
// ptfr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/ptfr_ring.sv
// ----------------------------------------------------------------------------
// ptfr_ring
// FIFO ring of resident pages: head and fill pointers over a ring RAM whose
// head entry is read continuously.
// ----------------------------------------------------------------------------
module ptfr_ring #(
    parameter int PAGES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ptfr_pkg::t_ring_cmd        i_cmd,
    input  logic [$clog2(PAGES)-1:0]   i_page,
    output ptfr_pkg::t_ring_stat       o_stat,
    output logic [$clog2(PAGES)-1:0]   o_head_page
);

    import ptfr_pkg::*;

    localparam int PW = $clog2(PAGES);
    localparam int FW = $clog2(PAGES + 1);

    logic [PW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [31:0]   tail_sum;
    logic [PW-1:0] tail;

    assign tail_sum = 32'(r_head) + 32'(r_fill);
    assign tail     = PW'((tail_sum >= 32'(PAGES)) ? (tail_sum - 32'(PAGES)) : tail_sum);

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.advance) begin
            n_head = (r_head == PW'(PAGES - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_cmd.append && !i_cmd.advance) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    ptfr_ram #(
        .WIDTH (PW),
        .DEPTH (PAGES)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (tail),
        .i_wr_data (i_page),
        .i_rd_addr (r_head),
        .o_rd_data (o_head_page)
    );

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FW'(PAGES));

endmodule

>>> hdl/paged_translate_fifo_replace.sv
// ----------------------------------------------------------------------------
// paged_translate_fifo_replace
// Page table with FIFO replacement. Translates read and write accesses,
// installs pages into frames and evicts the oldest resident page on a miss.
//
//   Channel   Valid          Ready          Payload
//   request   i_in_valid     o_in_ready     i_in_data  (ptfr_pkg::t_req)
//   response  o_out_valid    i_out_ready    o_out_data (ptfr_pkg::t_rsp)
//   config    i_cfg_valid    o_cfg_ready    i_cfg_data (pages_in_use)
//
// A hit, install or rejected request passes through S_LOOK and S_EMIT, a fault
// also through S_EVICT and S_FILL; the page table RAM's single read and write
// port sets this, as a fault reads two entries and writes two. After reset the
// page table is swept clear in S_CLEAR, during which no request is taken. A new
// request is taken while an earlier response still waits in the output register.
// ----------------------------------------------------------------------------
module paged_translate_fifo_replace #(
    parameter int PAGES       = 64,
    parameter int OFFSET_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ptfr_pkg::t_req                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ptfr_pkg::t_rsp                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptfr_pkg::CFG_W-1:0]    i_cfg_data
);

    import ptfr_pkg::*;

    localparam int PW = $clog2(PAGES);
    localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((32'd1 << OFFSET_BITS) - 32'd1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_EVICT = 6'b001000,
        S_FILL  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_clr_idx, n_clr_idx;
    logic [CFG_W-1:0]  r_pages_in_use;
    t_req              r_req, n_req;
    logic [PW-1:0]     r_page_idx, n_page_idx;
    logic              r_ok, n_ok;
    logic [PW-1:0]     r_old, n_old;
    logic [FRAME_W-1:0] r_frame, n_frame;
    t_rsp              r_res, n_res;
    logic              r_o_valid, n_o_valid;
    t_rsp              r_o_data, n_o_data;

    logic [ADDR_W-1:0] in_page;
    logic              in_ok;
    logic              tbl_we;
    logic [PW-1:0]     tbl_wa;
    t_pte              tbl_wd;
    logic [PW-1:0]     tbl_ra;
    t_pte              tbl_rd;
    t_ring_cmd         ring_cmd;
    t_ring_stat        ring_stat;
    logic [PW-1:0]     head_page;
    logic              is_access;

    function automatic logic [ADDR_W-1:0] f_phys(input logic [FRAME_W-1:0] frame,
                                                 input logic [ADDR_W-1:0] addr);
        return ADDR_W'(32'(frame) << OFFSET_BITS) | (addr & OFF_MASK);
    endfunction

    assign in_page = (i_in_data.func == FUNC_INSTALL) ? ADDR_W'(i_in_data.install_page)
                                                      : (i_in_data.logical_address >> OFFSET_BITS);
    assign in_ok   = (i_in_data.func != FUNC_READ || 1'b1)
                     && (i_in_data.func == FUNC_READ || i_in_data.func == FUNC_WRITE
                         || i_in_data.func == FUNC_INSTALL)
                     && (32'(in_page) < 32'(r_pages_in_use))
                     && (32'(in_page) < 32'(PAGES));
    assign is_access = (r_req.func == FUNC_READ) || (r_req.func == FUNC_WRITE);

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_req      = r_req;
        n_page_idx = r_page_idx;
        n_ok       = r_ok;
        n_old      = r_old;
        n_frame    = r_frame;
        n_res      = r_res;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_data   = r_o_data;
        tbl_we     = 1'b0;
        tbl_wa     = r_page_idx;
        tbl_wd     = '0;
        tbl_ra     = r_page_idx;
        ring_cmd   = '0;

        unique case (r_state)
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_wa    = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == PW'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                tbl_ra = in_page[PW-1:0];
                if (i_in_valid) begin
                    n_req      = i_in_data;
                    n_page_idx = in_page[PW-1:0];
                    n_ok       = in_ok;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res        = '0;
                n_res.status = ST_RANGE;
                n_state      = S_EMIT;
                if (!r_ok) begin
                    n_res.status = ST_RANGE;
                end else if (!is_access) begin
                    n_res.status = ST_INSTALLED;
                    tbl_wd       = '{frame: r_req.install_frame, resident: 1'b1,
                                     dirty: tbl_rd.dirty};
                    if (tbl_rd.resident) begin
                        tbl_we = 1'b1;
                    end else if (!ring_stat.full) begin
                        tbl_we          = 1'b1;
                        ring_cmd.append = 1'b1;
                    end
                end else if (tbl_rd.resident) begin
                    n_res.status           = ST_HIT;
                    n_res.physical_address = f_phys(tbl_rd.frame, r_req.logical_address);
                    tbl_we                 = (r_req.func == FUNC_WRITE);
                    tbl_wd                 = '{frame: tbl_rd.frame, resident: 1'b1,
                                               dirty: 1'b1};
                end else if (ring_stat.empty) begin
                    n_res.status = ST_NO_FRAME;
                end else begin
                    n_old   = head_page;
                    tbl_ra  = head_page;
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                tbl_we                 = 1'b1;
                tbl_wa                 = r_old;
                tbl_wd                 = '{frame: tbl_rd.frame, resident: 1'b0, dirty: 1'b0};
                n_frame                = tbl_rd.frame;
                n_res.status           = ST_FAULT;
                n_res.physical_address = f_phys(tbl_rd.frame, r_req.logical_address);
                n_res.evicted_page     = PAGE_W'(r_old);
                n_res.needs_writeback  = tbl_rd.dirty;
                n_state                = S_FILL;
            end
            S_FILL: begin
                tbl_we           = 1'b1;
                tbl_wd           = '{frame: r_frame, resident: 1'b1,
                                     dirty: (r_req.func == FUNC_WRITE)};
                ring_cmd.append  = 1'b1;
                ring_cmd.advance = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_data  = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_idx      <= '0;
            r_pages_in_use <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                r_pages_in_use <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_page_idx <= n_page_idx;
        r_ok       <= n_ok;
        r_old      <= n_old;
        r_frame    <= n_frame;
        r_res      <= n_res;
        r_o_data   <= n_o_data;
    end

    ptfr_ram #(
        .WIDTH ($bits(t_pte)),
        .DEPTH (PAGES)
    ) u_table_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_wa),
        .i_wr_data (tbl_wd),
        .i_rd_addr (tbl_ra),
        .o_rd_data (tbl_rd)
    );

    ptfr_ring #(
        .PAGES (PAGES)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ring_cmd),
        .i_page      (r_page_idx),
        .o_stat      (ring_stat),
        .o_head_page (head_page)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_cfg_ready = 1'b1;

endmodule

>>> hdl/ptfr_checker.sv
// ----------------------------------------------------------------------------
// ptfr_checker
// Port-level checks for the paged translation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "paged_translate_fifo_replace_assert.svh"

module ptfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input ptfr_pkg::t_req             i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input ptfr_pkg::t_rsp             o_out_data,
    input logic                       i_cfg_valid,
    input logic                       o_cfg_ready,
    input logic [ptfr_pkg::CFG_W-1:0] i_cfg_data
);

    import ptfr_pkg::*;

    `PTFR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "response changed while stalled")

    `PTFR_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "request taken while another is in flight")

    `PTFR_ASSERT_NOW(a_phys_zero, o_out_valid && o_out_data.status != ST_HIT && o_out_data.status != ST_FAULT, o_out_data.physical_address == '0, "address given without translation")

    `PTFR_ASSERT_NOW(a_evict_zero, o_out_valid && o_out_data.status != ST_FAULT, o_out_data.evicted_page == '0 && !o_out_data.needs_writeback, "eviction reported without a fault")

endmodule

bind paged_translate_fifo_replace ptfr_checker u_ptfr_checker (.*);

>>> sim/paged_translate_fifo_replace_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_translate_fifo_replace_tb
// Self-checking bench for the FIFO page replacement block. A scoreboard keeps
// its own page table, resident and dirty marks and replacement ring, works out
// the response to every accepted request and checks each response in order.
// Directed requests cover the corner cases. Random requests follow under
// several page counts, with both sides stalling at varying rates.
// ----------------------------------------------------------------------------
module paged_translate_fifo_replace_tb;
    import ptfr_pkg::*;

    localparam int NUM_PAGES     = 64;
    localparam int OFFSET_BITS   = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int SEGMENT_ITEMS = 75;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    class translation_scoreboard;
        logic [FRAME_W-1:0] frame_of [NUM_PAGES];
        bit resident [NUM_PAGES];
        bit dirty [NUM_PAGES];
        int ring [NUM_PAGES];
        int head;
        int fill;
        int pages_in_use;
        int errors;
        t_rsp awaited [$];

        function new();
            head = 0;
            fill = 0;
            pages_in_use = 0;
            errors = 0;
            foreach (resident[i]) begin
                resident[i] = 1'b0;
                dirty[i] = 1'b0;
            end
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int pg;
            int victim;
            rsp = '0;
            rsp.status = ST_RANGE;
            if (req.func == FUNC_INSTALL) begin
                pg = int'(req.install_page);
                if (pg < pages_in_use) begin
                    rsp.status = ST_INSTALLED;
                    if (resident[pg]) begin
                        frame_of[pg] = req.install_frame;
                    end else if (fill < NUM_PAGES) begin
                        frame_of[pg] = req.install_frame;
                        resident[pg] = 1'b1;
                        ring[(head + fill) % NUM_PAGES] = pg;
                        fill++;
                    end
                end
            end else if (req.func == FUNC_READ || req.func == FUNC_WRITE) begin
                pg = int'(req.logical_address >> OFFSET_BITS);
                if (pg < pages_in_use && pg < NUM_PAGES) begin
                    rsp.status = ST_HIT;
                    if (!resident[pg]) begin
                        if (fill == 0) begin
                            rsp.status = ST_NO_FRAME;
                        end else begin
                            // The oldest page gives up its frame to the missing one.
                            victim = ring[head];
                            rsp.status = ST_FAULT;
                            rsp.evicted_page = PAGE_W'(victim);
                            rsp.needs_writeback = dirty[victim];
                            frame_of[pg] = frame_of[victim];
                            resident[victim] = 1'b0;
                            dirty[victim] = 1'b0;
                            resident[pg] = 1'b1;
                            ring[(head + fill) % NUM_PAGES] = pg;
                            head = (head + 1) % NUM_PAGES;
                        end
                    end
                    if (rsp.status != ST_NO_FRAME) begin
                        rsp.physical_address = {frame_of[pg],
                                                req.logical_address[OFFSET_BITS-1:0]};
                        if (req.func == FUNC_WRITE) begin
                            dirty[pg] = 1'b1;
                        end
                    end
                end
            end
            awaited.push_back(rsp);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                $display("%0t: response with no request outstanding, actual %p", $time, got);
                errors++;
            end else begin
                want = awaited.pop_front();
                compare("status", 32'(want.status), 32'(got.status));
                compare("physical_address", 32'(want.physical_address),
                        32'(got.physical_address));
                compare("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
                compare("needs_writeback", 32'(want.needs_writeback),
                        32'(got.needs_writeback));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_req              i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_rsp              o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    translation_scoreboard sb;
    int send_idle = 20;
    int recv_idle = 84;
    int quiet_cycles = 0;

    paged_translate_fifo_replace uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_response(o_out_data);
        end
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL paged_translate_fifo_replace");
            $finish;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic t_req make_request(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                                          logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
        t_req req;
        req.func = func;
        req.logical_address = addr;
        req.install_page = page;
        req.install_frame = frame;
        return req;
    endfunction

    function automatic t_req random_request(int pages);
        t_req req;
        int pick;
        int pg;
        req.logical_address = ADDR_W'($urandom_range(0, 16'hFFFF));
        req.install_page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        req.install_frame = FRAME_W'($urandom_range(0, NUM_PAGES - 1));
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
            pg = $urandom_range(0, NUM_PAGES - 1);
        end else begin
            pg = $urandom_range(0, pages - 1);
        end
        if (pick < 4) begin
            req.func = FUNC_UNUSED;
        end else if (pick < 34) begin
            req.func = FUNC_INSTALL;
            req.install_page = PAGE_W'(pg);
        end else begin
            req.func = pick[0] ? FUNC_WRITE : FUNC_READ;
            req.logical_address[ADDR_W-1:OFFSET_BITS] = PAGE_W'(pg);
        end
        return req;
    endfunction

    task automatic send_request(t_req req);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    task automatic write_pages(int pages);
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CFG_W'(pages);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.pages_in_use = pages;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int seg;
        int pages;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With no pages configured every request is out of range.
        write_pages(0);
        send_request(make_request(FUNC_INSTALL, 16'h0000, 6'd0, 6'd9));
        send_request(make_request(FUNC_READ, 16'h0000, 6'd0, 6'd0));
        send_request(make_request(FUNC_UNUSED, 16'hFFFF, 6'h3F, 6'h3F));

        write_pages(NUM_PAGES);
        send_request(make_request(FUNC_READ, 16'h0000, 6'd0, 6'd0));
        send_request(make_request(FUNC_WRITE, 16'hFFFF, 6'h3F, 6'h3F));
        send_request(make_request(FUNC_INSTALL, 16'h0000, 6'd0, 6'h3F));
        send_request(make_request(FUNC_INSTALL, 16'hFFFF, 6'h3F, 6'd0));
        send_request(make_request(FUNC_INSTALL, 16'h1234, 6'd5, 6'h2A));
        send_request(make_request(FUNC_READ, 16'h03FF, 6'd0, 6'd0));
        send_request(make_request(FUNC_WRITE, 16'hFC00, 6'd0, 6'd0));
        send_request(make_request(FUNC_INSTALL, 16'h0000, 6'h3F, 6'h15));
        send_request(make_request(FUNC_READ, 16'hFFFF, 6'd0, 6'd0));
        send_request(make_request(FUNC_READ, 16'h0800, 6'd0, 6'd0));
        send_request(make_request(FUNC_WRITE, 16'h0C01, 6'd0, 6'd0));
        send_request(make_request(FUNC_UNUSED, 16'hFFFF, 6'h3F, 6'h3F));
        send_request(make_request(FUNC_READ, 16'hFC00, 6'd0, 6'd0));
        send_request(make_request(FUNC_INSTALL, 16'h0000, 6'd0, 6'd1));

        write_pages(1);
        send_request(make_request(FUNC_INSTALL, 16'h0000, 6'd1, 6'd7));
        send_request(make_request(FUNC_READ, 16'h0400, 6'd0, 6'd0));
        send_request(make_request(FUNC_READ, 16'h0000, 6'd0, 6'd0));

        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: pages = $urandom_range(1, 8);
                1: pages = NUM_PAGES;
                2: pages = $urandom_range(9, 40);
                3: pages = NUM_PAGES - 1;
                4: pages = $urandom_range(41, NUM_PAGES);
                default: pages = NUM_PAGES;
            endcase
            send_idle = (seg < 2) ? 20 : (seg < 4) ? 84 : 0;
            recv_idle = (seg < 2) ? 84 : (seg < 4) ? 20 : 0;
            write_pages(pages);
            repeat (SEGMENT_ITEMS) send_request(random_request(pages));
        end

        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("PASS paged_translate_fifo_replace");
        end else begin
            $display("FAIL paged_translate_fifo_replace");
        end
        $finish;
    end

endmodule
